// ----- rtl/uda_pkg.sv -----
package uda_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned DigitCount = 10;
  localparam int unsigned CharWidth  = 6;
  localparam int unsigned StepCount  = ValueWidth;

  localparam logic [CharWidth-1:0] AsciiZero = CharWidth'(48);

  typedef logic [3:0]                  bcd_digit_t;
  typedef bcd_digit_t [DigitCount-1:0] bcd_word_t;

  // finished conversion offered by the dabble unit to the emitter
  typedef struct packed {
    logic      valid;
    bcd_word_t digits;
  } uda_bcd_t;

endpackage

// ----- rtl/uda_chan_if.sv -----
interface uda_in_if;
  import uda_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ValueWidth-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface uda_out_if;
  import uda_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CharWidth-1:0] digit_char;
  logic                 last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

// ----- rtl/uda_dabble.sv -----
module uda_dabble (
  input  logic              clk,
  input  logic              rst_n,
  uda_in_if.sink            in_if,
  output uda_pkg::uda_bcd_t bcd_o,
  input  logic              take_i
);
  import uda_pkg::*;

  localparam int unsigned CntWidth = $clog2(StepCount);
  localparam logic [CntWidth-1:0] StepLast = CntWidth'(StepCount - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CntWidth-1:0]     cnt_r, cnt_nxt;
  logic [ValueWidth-1:0]   sh_r;
  bcd_word_t               bcd_r;
  bcd_word_t               adj;
  logic [DigitCount*4-1:0] adj_bits;
  logic                    accept;
  logic                    bcd_ok;

  assign in_if.ready  = (state_r == S_IDLE);
  assign accept       = in_if.valid && in_if.ready;
  assign bcd_o.valid  = (state_r == S_DONE);
  assign bcd_o.digits = bcd_r;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < DigitCount; d++) begin
      adj[d] = (bcd_r[d] >= 4'd5) ? bcd_r[d] + 4'd3 : bcd_r[d];
    end
  end

  // flat view so the shift moves bits across digit boundaries
  assign adj_bits = adj;

  always_comb begin
    bcd_ok = 1'b1;
    for (int d = 0; d < DigitCount; d++) begin
      if (bcd_r[d] > 4'd9) begin
        bcd_ok = 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_CONV;
          cnt_nxt   = '0;
        end
      end
      S_CONV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == StepLast) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (take_i) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sh_r  <= in_if.value;
      bcd_r <= '0;
    end else if (state_r == S_CONV) begin
      bcd_r <= {adj_bits[DigitCount*4-2:0], sh_r[ValueWidth-1]};
      sh_r  <= {sh_r[ValueWidth-2:0], 1'b0};
    end
  end

  a_conv_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CONV && cnt_r == StepLast) |=> (state_r == S_DONE))
    else $error("conversion did not finish after the last step");

  a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> bcd_ok)
    else $error("finished conversion holds a digit above nine");

  a_take_done: assert property (@(posedge clk) disable iff (!rst_n)
    take_i |-> (state_r == S_DONE))
    else $error("emitter took a conversion that was not finished");

endmodule

// ----- rtl/uda_emit.sv -----
module uda_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  uda_pkg::uda_bcd_t bcd_i,
  output logic              take_o,
  uda_out_if.source         out_if
);
  import uda_pkg::*;

  localparam int unsigned IdxWidth = $clog2(DigitCount);

  logic                 active_r;
  logic [IdxWidth-1:0]  idx_r;
  bcd_word_t            digits_r;
  logic                 out_valid_r;
  logic [CharWidth-1:0] out_char_r;
  logic                 out_last_r;
  logic [IdxWidth-1:0]  top;
  logic                 load;
  logic                 adv;

  // most significant nonzero digit, digit zero when the number is zero
  always_comb begin
    top = '0;
    for (int d = 0; d < DigitCount; d++) begin
      if (bcd_i.digits[d] != 4'd0) begin
        top = IdxWidth'(d);
      end
    end
  end

  assign load   = bcd_i.valid && !active_r;
  assign take_o = load;
  assign adv    = active_r && (!out_valid_r || out_if.ready);

  assign out_if.valid      = out_valid_r;
  assign out_if.digit_char = out_char_r;
  assign out_if.last_digit = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        active_r <= 1'b1;
        idx_r    <= top;
      end else if (adv) begin
        if (idx_r == '0) begin
          active_r <= 1'b0;
        end else begin
          idx_r <= idx_r - 1'b1;
        end
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digits_r <= bcd_i.digits;
    end
    if (adv) begin
      out_char_r <= AsciiZero + {2'b00, digits_r[idx_r]};
      out_last_r <= (idx_r == '0);
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (idx_r <= IdxWidth'(DigitCount - 1)))
    else $error("digit index beyond the digit count");

  a_load_top: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (active_r && idx_r == $past(top)))
    else $error("emitter did not start at the leading digit");

  a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> active_r)
    else $error("emitter went idle before the final digit");

endmodule

// ----- rtl/unsigned_to_decimal_ascii.sv -----
// Converts a 32-bit unsigned value to decimal ASCII text, one digit per out request,
// most significant first, without leading zeros (zero gives a single '0'); last_digit
// marks the final digit. A single shift-and-add-3 unit runs 32 steps per value: after a
// request is accepted, in_if.ready stays low through the 32 steps and the handoff to the
// digit emitter, so no new request is taken until the value is handed off; the emitter
// then registers the first digit. Digits leave one per cycle while the sink is ready,
// through an output register, while the next value is converted; when the sink
// stalls long enough that the previous digits are still going out, the finished value
// waits in the converter and the input stays blocked until the emitter takes it.
module unsigned_to_decimal_ascii (
  input  logic      clk,
  input  logic      rst_n,
  uda_in_if.sink    in_if,
  uda_out_if.source out_if
);
  import uda_pkg::*;

  uda_bcd_t bcd;
  logic     take;

  uda_dabble u_dabble (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .bcd_o  (bcd),
    .take_i (take)
  );

  uda_emit u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .bcd_i  (bcd),
    .take_o (take),
    .out_if (out_if)
  );

endmodule
